// ===== hw/rtl/avt_pkg.sv =====
// Shared constants and register codes for the affine vertex transform.
package avt_pkg;

   localparam int FracBits  = 16;
   localparam int DataW     = 32;
   localparam int CoefW     = 64;
   localparam int NumComp   = 3;
   localparam int AddrW     = 6;
   localparam int RegIdxW   = 3;
   localparam int ProdW     = 2 * DataW;
   localparam int SumW      = ProdW + 2;

   localparam logic [CoefW-1:0] CoefOneLo = CoefW'(64'd1 << FracBits);
   localparam logic [CoefW-1:0] CoefOneHi = CoefW'(64'd1 << (FracBits + DataW));

   typedef enum logic [RegIdxW-1:0] {
      REG_X_COEF_A = 3'd0,
      REG_X_COEF_B = 3'd1,
      REG_Y_COEF_A = 3'd2,
      REG_Y_COEF_B = 3'd3,
      REG_Z_COEF_A = 3'd4,
      REG_Z_COEF_B = 3'd5
   } csr_reg_type;

endpackage

// ===== hw/rtl/affine_vertex_transform_top.sv =====
// Top level: 4x4 affine transform of Q16.16 vectors, four-stage pipeline.
//
// Transforms one 3-component signed Q16.16 vector per beat by the matrix held in the six
// 64-bit registers (register i at byte address 8*i, identity after reset); action 0 adds
// the translation row, action 1 leaves it out. The pipeline takes one beat per clock when
// not stalled and passes each beat through its input register, nine 32x32 multipliers,
// a four-term adder (three products and the translation), floor shift and saturation. A
// stall on the result side holds the whole pipeline; overflow flags a saturated component.
// Write the matrix only while no beat is in flight.
module affine_vertex_transform_top
   import avt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_action,
   input  logic signed [DataW-1:0] req_in_x,
   input  logic signed [DataW-1:0] req_in_y,
   input  logic signed [DataW-1:0] req_in_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [DataW-1:0] rsp_out_x,
   output logic signed [DataW-1:0] rsp_out_y,
   output logic signed [DataW-1:0] rsp_out_z,
   output logic                    rsp_overflow,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [AddrW-1:0]        paddr,
   input  logic [CoefW-1:0]        pwdata,
   output logic [CoefW-1:0]        prdata,
   output logic                    pready
);

   logic [CoefW-1:0] coef_ff [2*NumComp];
   logic [CoefW-1:0] coef_in [2*NumComp];

   logic                    adv;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_point_ff, s1_point_in;
   logic signed [DataW-1:0] s1_vec_ff [NumComp];
   logic signed [DataW-1:0] s1_vec_in [NumComp];

   logic                    s2_valid_ff, s2_valid_in;
   logic signed [ProdW-1:0] s2_prod_ff [NumComp][NumComp];
   logic signed [ProdW-1:0] s2_prod_in [NumComp][NumComp];
   logic signed [DataW-1:0] s2_trans_ff [NumComp];
   logic signed [DataW-1:0] s2_trans_in [NumComp];

   logic                    s3_valid_ff, s3_valid_in;
   logic signed [SumW-1:0]  s3_sum_ff [NumComp];
   logic signed [SumW-1:0]  s3_sum_in [NumComp];

   logic                    out_valid_ff, out_valid_in;
   logic signed [DataW-1:0] out_res_ff [NumComp];
   logic signed [DataW-1:0] out_res_in [NumComp];
   logic                    out_ovf_ff, out_ovf_in;
   logic [NumComp-1:0]      sat;

   // configuration registers
   assign pready = 1'b1;

   always_comb begin
      for (int i = 0; i < 2*NumComp; i++) begin
         coef_in[i] = coef_ff[i];
      end
      if (psel && penable && pwrite) begin
         unique case (csr_reg_type'(paddr[AddrW-1:AddrW-RegIdxW]))
            REG_X_COEF_A: coef_in[0] = pwdata;
            REG_X_COEF_B: coef_in[1] = pwdata;
            REG_Y_COEF_A: coef_in[2] = pwdata;
            REG_Y_COEF_B: coef_in[3] = pwdata;
            REG_Z_COEF_A: coef_in[4] = pwdata;
            REG_Z_COEF_B: coef_in[5] = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg_type'(paddr[AddrW-1:AddrW-RegIdxW]))
         REG_X_COEF_A: prdata = coef_ff[0];
         REG_X_COEF_B: prdata = coef_ff[1];
         REG_Y_COEF_A: prdata = coef_ff[2];
         REG_Y_COEF_B: prdata = coef_ff[3];
         REG_Z_COEF_A: prdata = coef_ff[4];
         REG_Z_COEF_B: prdata = coef_ff[5];
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= CoefOneLo;
         coef_ff[1] <= '0;
         coef_ff[2] <= CoefOneHi;
         coef_ff[3] <= '0;
         coef_ff[4] <= '0;
         coef_ff[5] <= CoefOneLo;
      end else begin
         for (int i = 0; i < 2*NumComp; i++) begin
            coef_ff[i] <= coef_in[i];
         end
      end
   end

   // pipeline moves as one; a held result freezes every stage
   assign adv       = !out_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // stage 1: input beat
   assign s1_valid_in  = req_valid;
   assign s1_point_in  = !req_action;
   assign s1_vec_in[0] = req_in_x;
   assign s1_vec_in[1] = req_in_y;
   assign s1_vec_in[2] = req_in_z;

   // stage 2: products, column c of the matrix
   for (genvar c = 0; c < NumComp; c++) begin : g_comp
      logic signed [DataW-1:0] m0, m1, m2, tr;
      logic signed [SumW-1:0]  shifted;
      assign m0 = coef_ff[2*c][DataW-1:0];
      assign m1 = coef_ff[2*c][CoefW-1:DataW];
      assign m2 = coef_ff[2*c+1][DataW-1:0];
      assign tr = coef_ff[2*c+1][CoefW-1:DataW];

      assign s2_prod_in[c][0] = m0 * s1_vec_ff[0];
      assign s2_prod_in[c][1] = m1 * s1_vec_ff[1];
      assign s2_prod_in[c][2] = m2 * s1_vec_ff[2];
      assign s2_trans_in[c]   = s1_point_ff ? tr : '0;

      // stage 3: exact sum
      assign s3_sum_in[c] = SumW'(s2_prod_ff[c][0]) + SumW'(s2_prod_ff[c][1])
                          + SumW'(s2_prod_ff[c][2])
                          + (SumW'(s2_trans_ff[c]) <<< FracBits);

      // stage 4: floor shift and saturation
      assign shifted = s3_sum_ff[c] >>> FracBits;
      assign sat[c]  = !((&shifted[SumW-1:DataW-1]) || !(|shifted[SumW-1:DataW-1]));
      assign out_res_in[c] = !sat[c] ? shifted[DataW-1:0]
                           : shifted[SumW-1] ? {1'b1, {(DataW-1){1'b0}}}
                           : {1'b0, {(DataW-1){1'b1}}};
   end

   assign s2_valid_in  = s1_valid_ff;
   assign s3_valid_in  = s2_valid_ff;
   assign out_valid_in = s3_valid_ff;
   assign out_ovf_in   = |sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_point_ff <= s1_point_in;
         out_ovf_ff  <= out_ovf_in;
         for (int c = 0; c < NumComp; c++) begin
            s1_vec_ff[c]   <= s1_vec_in[c];
            s2_trans_ff[c] <= s2_trans_in[c];
            s3_sum_ff[c]   <= s3_sum_in[c];
            out_res_ff[c]  <= out_res_in[c];
            for (int j = 0; j < NumComp; j++) begin
               s2_prod_ff[c][j] <= s2_prod_in[c][j];
            end
         end
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_x    = out_res_ff[0];
   assign rsp_out_y    = out_res_ff[1];
   assign rsp_out_z    = out_res_ff[2];
   assign rsp_overflow = out_ovf_ff;

   // a flagged result holds at least one rail value
   a_ovf_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |->
         (rsp_out_x == {1'b0, {(DataW-1){1'b1}}} || rsp_out_x == {1'b1, {(DataW-1){1'b0}}} ||
          rsp_out_y == {1'b0, {(DataW-1){1'b1}}} || rsp_out_y == {1'b1, {(DataW-1){1'b0}}} ||
          rsp_out_z == {1'b0, {(DataW-1){1'b1}}} || rsp_out_z == {1'b1, {(DataW-1){1'b0}}}))
      else $error("overflow flagged without a saturated component");

   // an accepted beat reaches the sum stage once the pipe has advanced it past the product stage
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 adv ##1 adv |=> s3_valid_ff)
      else $error("beat lost in the pipeline");

   // a sum-stage beat always reaches the output register when the pipe moves
   a_exit: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && adv) |=> rsp_valid)
      else $error("beat lost before the output register");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the affine vertex transform: random and directed vectors.
module tb_top
   import avt_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic       ActPoint     = 1'b0;
   localparam logic       ActDirection = 1'b1;
   localparam logic [RegIdxW-1:0] RegUnusedA = 3'd6;
   localparam logic [RegIdxW-1:0] RegUnusedB = 3'd7;
   localparam logic signed [DataW-1:0] QHigh = 32'sh7FFF_FFFF;
   localparam logic signed [DataW-1:0] QLow  = 32'sh8000_0000;
   localparam logic signed [DataW-1:0] QOne  = 32'sh1 <<< FracBits;
   localparam logic signed [DataW-1:0] QHalf = 32'sh1 <<< (FracBits - 1);
   localparam logic signed [SumW-1:0]  SatMax = (SumW'(1) <<< (DataW - 1)) - 1;
   localparam logic signed [SumW-1:0]  SatMin = -(SumW'(1) <<< (DataW - 1));
   localparam int StallLimit = 2000;
   localparam int BeatsPerPhase = 95;

   typedef enum {MAT_MIXED, MAT_SMALL, MAT_EXTREME, MAT_FULL, MAT_UNIFORM} matrix_mode_type;

   typedef struct packed {
      logic                    action;
      logic signed [DataW-1:0] in_x;
      logic signed [DataW-1:0] in_y;
      logic signed [DataW-1:0] in_z;
   } vertex_beat_type;

   typedef struct packed {
      logic signed [DataW-1:0] out_x;
      logic signed [DataW-1:0] out_y;
      logic signed [DataW-1:0] out_z;
      logic                    overflow;
   } vertex_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_action = 1'b0;
   logic signed [DataW-1:0] req_in_x = '0;
   logic signed [DataW-1:0] req_in_y = '0;
   logic signed [DataW-1:0] req_in_z = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [DataW-1:0] rsp_out_x;
   logic signed [DataW-1:0] rsp_out_y;
   logic signed [DataW-1:0] rsp_out_z;
   logic                    rsp_overflow;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [AddrW-1:0]        paddr = '0;
   logic [CoefW-1:0]        pwdata = '0;
   logic [CoefW-1:0]        prdata;
   logic                    pready;

   logic [CoefW-1:0]  matrix_regs [2*NumComp];
   vertex_beat_type   pending_beats [$];
   vertex_result_type vertex_expect_q [$];
   bit                req_taken = 1'b0;
   bit                steady_run = 1'b0;
   int                mismatches = 0;
   int                idle_cycles = 0;

   affine_vertex_transform_top DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one output component: exact sum of products, floor shift, saturate
   function automatic logic signed [DataW-1:0] transform_axis(input logic [CoefW-1:0] ca,
      input logic [CoefW-1:0] cb, input vertex_beat_type b, inout logic sat);
      logic signed [DataW-1:0] m0, m1, m2, tr;
      logic signed [ProdW-1:0] p0, p1, p2;
      logic signed [SumW-1:0]  acc, tsh;
      m0 = ca[DataW-1:0];
      m1 = ca[CoefW-1:DataW];
      m2 = cb[DataW-1:0];
      tr = cb[CoefW-1:DataW];
      p0 = m0 * b.in_x;
      p1 = m1 * b.in_y;
      p2 = m2 * b.in_z;
      acc = p0;
      acc = acc + p1;
      acc = acc + p2;
      if (b.action == ActPoint) begin
         tsh = tr;
         acc = acc + (tsh <<< FracBits);
      end
      acc = acc >>> FracBits;
      if (acc > SatMax) begin
         sat = 1'b1;
         return QHigh;
      end
      if (acc < SatMin) begin
         sat = 1'b1;
         return QLow;
      end
      return acc[DataW-1:0];
   endfunction

   function automatic vertex_result_type predict_vertex(input vertex_beat_type b);
      vertex_result_type r;
      logic sat;
      sat = 1'b0;
      r.out_x = transform_axis(matrix_regs[REG_X_COEF_A], matrix_regs[REG_X_COEF_B], b, sat);
      r.out_y = transform_axis(matrix_regs[REG_Y_COEF_A], matrix_regs[REG_Y_COEF_B], b, sat);
      r.out_z = transform_axis(matrix_regs[REG_Z_COEF_A], matrix_regs[REG_Z_COEF_B], b, sat);
      r.overflow = sat;
      return r;
   endfunction

   function automatic logic signed [DataW-1:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return QHigh;
         1: return QLow;
         2: return '0;
         3: return -1;
         default: return QOne;
      endcase
   endfunction

   // roughly +/-8.0
   function automatic logic signed [DataW-1:0] small_fixed();
      return $signed($urandom_range(0, 32'h10_0000)) - 32'sh8_0000;
   endfunction

   function automatic logic signed [DataW-1:0] rand_fixed();
      case ($urandom_range(0, 7))
         0: return pick_extreme();
         1, 2, 3: return $urandom;
         default: return small_fixed();
      endcase
   endfunction

   function automatic vertex_beat_type rand_beat();
      vertex_beat_type b;
      b.action = 1'($urandom_range(0, 1));
      b.in_x = rand_fixed();
      b.in_y = rand_fixed();
      b.in_z = rand_fixed();
      return b;
   endfunction

   task automatic push_beat(input logic act, input logic signed [DataW-1:0] x,
      input logic signed [DataW-1:0] y, input logic signed [DataW-1:0] z);
      pending_beats.push_back('{act, x, y, z});
   endtask

   task automatic csr_write(input logic [RegIdxW-1:0] idx, input logic [CoefW-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= AddrW'(idx) << 3;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx <= REG_Z_COEF_B) matrix_regs[idx] = data;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // uniform: every coefficient lin, translations tr
   task automatic load_matrix(input matrix_mode_type mode, input logic [DataW-1:0] lin = '0,
      input logic [DataW-1:0] tr = '0);
      csr_reg_type r;
      logic [CoefW-1:0] v;
      r = r.first();
      repeat (r.num()) begin
         case (mode)
            MAT_MIXED:   v = {rand_fixed(), rand_fixed()};
            MAT_SMALL:   v = {small_fixed(), small_fixed()};
            MAT_EXTREME: v = {pick_extreme(), pick_extreme()};
            MAT_FULL:    v = {$urandom, $urandom};
            default: begin
               if (r inside {REG_X_COEF_B, REG_Y_COEF_B, REG_Z_COEF_B}) v = {tr, lin};
               else v = {lin, lin};
            end
         endcase
         csr_write(r, v);
         r = r.next();
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_beats.size() != 0 || req_valid || vertex_expect_q.size() != 0);
   endtask

   always @(negedge clock) begin : drive_req
      vertex_beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // stalled beat held as is
      end else if (pending_beats.size() != 0 && (steady_run || $urandom_range(0, 99) >= 21)) begin
         b = pending_beats.pop_front();
         req_valid <= 1'b1;
         req_action <= b.action;
         req_in_x <= b.in_x;
         req_in_y <= b.in_y;
         req_in_z <= b.in_z;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !steady_run && ($urandom_range(0, 99) < 21);
   end

   always @(posedge clock) begin : watch_beats
      vertex_result_type got, want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_x, rsp_out_y, rsp_out_z, rsp_overflow};
            if (vertex_expect_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected result x=%0d y=%0d z=%0d ovf=%0b", $realtime,
                           got.out_x, got.out_y, got.out_z, got.overflow);
               mismatches++;
            end else begin
               want = vertex_expect_q.pop_front();
               if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                   got.out_z !== want.out_z || got.overflow !== want.overflow) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch exp %0d %0d %0d %0b, got %0d %0d %0d %0b",
                              $realtime, want.out_x, want.out_y, want.out_z, want.overflow,
                              got.out_x, got.out_y, got.out_z, got.overflow);
                  mismatches++;
               end
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken)
            vertex_expect_q.push_back(predict_vertex('{req_action, req_in_x, req_in_y, req_in_z}));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      matrix_mode_type plan [8];
      plan = '{MAT_MIXED, MAT_SMALL, MAT_EXTREME, MAT_FULL,
               MAT_MIXED, MAT_SMALL, MAT_EXTREME, MAT_FULL};
      foreach (matrix_regs[i]) matrix_regs[i] = '0;
      matrix_regs[REG_X_COEF_A] = CoefOneLo;
      matrix_regs[REG_Y_COEF_A] = CoefOneHi;
      matrix_regs[REG_Z_COEF_B] = CoefOneLo;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity after reset
      push_beat(ActPoint, '0, '0, '0);
      push_beat(ActDirection, QHigh, QLow, -1);
      push_beat(ActPoint, QLow, QHigh, 1);
      push_beat(ActDirection, -1, -1, -1);
      push_beat(ActPoint, QOne, -QOne, QHalf);
      drain();

      // largest positive matrix: saturation both ways
      load_matrix(MAT_UNIFORM, QHigh, QHigh);
      push_beat(ActPoint, QHigh, QHigh, QHigh);
      push_beat(ActDirection, QHigh, QHigh, QHigh);
      push_beat(ActPoint, QLow, QLow, QLow);
      push_beat(ActPoint, '0, '0, '0);
      push_beat(ActDirection, '0, '0, '0);
      push_beat(ActPoint, 1, 1, 1);
      push_beat(ActPoint, -1, -1, -1);
      drain();

      // most negative matrix
      load_matrix(MAT_UNIFORM, QLow, QLow);
      push_beat(ActPoint, QLow, QLow, QLow);
      push_beat(ActPoint, QHigh, QHigh, QHigh);
      push_beat(ActDirection, '0, '0, '0);
      push_beat(ActPoint, '0, '0, '0);
      push_beat(ActPoint, 1, '0, '0);
      drain();

      // floor of negative fractions
      load_matrix(MAT_UNIFORM, QHalf, -1);
      push_beat(ActPoint, -1, '0, '0);
      push_beat(ActDirection, -1, '0, '0);
      push_beat(ActDirection, 1, '0, '0);
      push_beat(ActDirection, -1, -1, '0);
      push_beat(ActDirection, -1, -1, -1);
      drain();

      foreach (plan[p]) begin
         load_matrix(plan[p]);
         if (p == 0) begin
            csr_write(RegUnusedA, {$urandom, $urandom});
            csr_write(RegUnusedB, {$urandom, $urandom});
         end
         steady_run = (p == 3);
         repeat (BeatsPerPhase) pending_beats.push_back(rand_beat());
         drain();
         steady_run = 1'b0;
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && vertex_expect_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
